FILE: rtl/core/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; used by every module under rtl/core.
package ptw_pkg;

    localparam int TABLE_FRAMES_DEF = 64;
    localparam int IDX_W            = 9;
    localparam int SLOTS            = 512;
    localparam int OFS_W            = 12;
    localparam int VA_W             = 48;
    localparam int PA_W             = 52;
    localparam int PFN_W            = PA_W - OFS_W;
    localparam int ENTRY_W          = PA_W;
    localparam int FUNC_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int S_DATA_W         = 112;
    localparam int M_DATA_W         = 56;

    localparam logic [FUNC_W-1:0] FUNC_MAP    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNMAP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XLATE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RESERVED   = 2'd3;

    // present | writable for intermediate entries
    localparam logic [OFS_W-1:0] TABLE_FLAGS = 12'h003;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     result_addr;
    } res_t;

endpackage

FILE: rtl/core/four_level_page_table_walker_core.sv
// Four-level page table walker: stream ports, walk sequencer, table store,
// output register. Depends on ptw_pkg, ptw_walker, ptw_store.
//
// Use: one request word in on s_*, one response word out on m_* per request.
// s_tuser carries the operation (map, unmap, translate); s_tdata carries the
// virtual address, physical address and leaf flags. m_tuser carries the
// status, m_tdata the translated address (zero unless a translate hits).
// After reset the store is swept to zero, one entry per cycle, over all
// TABLE_FRAMES*512 entries (32768 at the default); s_tready stays low then.
// The frame allocator restarts at frame 1 (frame 0 is the root).
// One request is in flight at a time. Each table level is a read issue
// (S_READ), then a check of the registered read data (S_EVAL), on the
// single store port; map writes its leaf level without a read. A new
// request is taken once the previous result has moved into the output
// register; if the receiver stalls with that register full, the
// sequencer holds its result and s_tready stays low.
module four_level_page_table_walker_core #(
    parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [47:0] vaddr, [99:48] paddr, [111:100] entry_flags
    input  logic [ptw_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] func
    input  logic [ptw_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [51:0] result_addr, [55:52] zero
    output logic [ptw_pkg::M_DATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [ptw_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int FW = $clog2(TABLE_FRAMES);
    localparam int AW = FW + ptw_pkg::IDX_W;

    logic                          res_valid;
    logic                          res_ready;
    ptw_pkg::res_t                 res;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_addr;
    logic [ptw_pkg::ENTRY_W-1:0]   mem_wdata;
    logic [ptw_pkg::ENTRY_W-1:0]   mem_rdata;

    logic                          m_valid_reg, m_valid_next;
    ptw_pkg::res_t                 m_res_reg;

    ptw_walker #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .FW           (FW),
        .AW           (AW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_va     (s_tdata[47:0]),
        .in_pa     (s_tdata[99:48]),
        .in_flags  (s_tdata[111:100]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    ptw_store #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .AW           (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{(ptw_pkg::M_DATA_W - ptw_pkg::PA_W){1'b0}}, m_res_reg.result_addr};

endmodule

FILE: rtl/core/ptw_store.sv
// Table frame store: single-port synchronous RAM, registered read data.
// Depends on ptw_pkg.
module ptw_store #(
    parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF,
    parameter int AW           = $clog2(TABLE_FRAMES) + ptw_pkg::IDX_W
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic                         re,
    input  logic [AW-1:0]                addr,
    input  logic [ptw_pkg::ENTRY_W-1:0]  wdata,
    output logic [ptw_pkg::ENTRY_W-1:0]  rdata
);

    localparam int DEPTH = TABLE_FRAMES * ptw_pkg::SLOTS;

    logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [ptw_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ptw_walker.sv
// Walk sequencer: clearing pass, level-by-level read / allocate / write-back.
// Depends on ptw_pkg; drives ptw_store.
module ptw_walker #(
    parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF,
    parameter int FW           = $clog2(TABLE_FRAMES),
    parameter int AW           = FW + ptw_pkg::IDX_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptw_pkg::FUNC_W-1:0]    in_func,
    input  logic [ptw_pkg::VA_W-1:0]      in_va,
    input  logic [ptw_pkg::PA_W-1:0]      in_pa,
    input  logic [ptw_pkg::OFS_W-1:0]     in_flags,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ptw_pkg::res_t                 res,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_addr,
    output logic [ptw_pkg::ENTRY_W-1:0]   mem_wdata,
    input  logic [ptw_pkg::ENTRY_W-1:0]   mem_rdata
);

    localparam int DEPTH = TABLE_FRAMES * ptw_pkg::SLOTS;
    localparam int NW    = $clog2(TABLE_FRAMES + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     lv_reg, lv_next;
    logic [FW-1:0]                  frame_reg, frame_next;
    logic [NW-1:0]                  free_reg, free_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [ptw_pkg::FUNC_W-1:0]     func_reg;
    logic [ptw_pkg::VA_W-1:0]       va_reg;
    logic [ptw_pkg::ENTRY_W-1:0]    leaf_reg;
    logic [ptw_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ptw_pkg::PA_W-1:0]       result_reg, result_next;

    logic [ptw_pkg::IDX_W-1:0]      idx;
    logic [AW-1:0]                  slot;
    logic [ptw_pkg::PFN_W-1:0]      ent_pfn;
    logic                           ent_present;
    logic                           ent_follow;
    logic                           alloc_ok;
    logic                           accept;

    always_comb
    begin
        case (lv_reg)
            2'd0:    idx = va_reg[39 +: ptw_pkg::IDX_W];
            2'd1:    idx = va_reg[30 +: ptw_pkg::IDX_W];
            2'd2:    idx = va_reg[21 +: ptw_pkg::IDX_W];
            default: idx = va_reg[12 +: ptw_pkg::IDX_W];
        endcase
    end

    assign slot        = {frame_reg, idx};
    assign ent_present = mem_rdata[0];
    assign ent_pfn     = mem_rdata[ptw_pkg::ENTRY_W-1:ptw_pkg::OFS_W];
    assign ent_follow  = ent_present && (ent_pfn < ptw_pkg::PFN_W'(TABLE_FRAMES));
    assign alloc_ok    = free_reg < NW'(TABLE_FRAMES);
    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign res_valid   = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.result_addr = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        lv_next     = lv_reg;
        frame_next  = frame_reg;
        free_next   = free_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot;
        mem_wdata   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    lv_next     = 2'd0;
                    frame_next  = '0;
                    status_next = ptw_pkg::ST_OK;
                    result_next = '0;
                    if (in_func == ptw_pkg::FUNC_MAP || in_func == ptw_pkg::FUNC_UNMAP ||
                        in_func == ptw_pkg::FUNC_XLATE)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                if (lv_reg == 2'd3 && func_reg == ptw_pkg::FUNC_MAP)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = leaf_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (lv_reg != 2'd3)
                begin
                    if (ent_follow)
                    begin
                        frame_next = ent_pfn[FW-1:0];
                        lv_next    = lv_reg + 2'd1;
                        state_next = S_READ;
                    end
                    else if (func_reg == ptw_pkg::FUNC_MAP)
                    begin
                        if (alloc_ok)
                        begin
                            // fresh frames are still zero from the clearing pass
                            mem_we     = 1'b1;
                            mem_wdata  = {ptw_pkg::PFN_W'(free_reg), ptw_pkg::TABLE_FLAGS};
                            frame_next = free_reg[FW-1:0];
                            free_next  = free_reg + NW'(1);
                            lv_next    = lv_reg + 2'd1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            status_next = ptw_pkg::ST_NO_FRAMES;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        status_next = ptw_pkg::ST_NOT_MAPPED;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                    if (!ent_present)
                    begin
                        status_next = ptw_pkg::ST_NOT_MAPPED;
                    end
                    if (func_reg == ptw_pkg::FUNC_UNMAP)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (ent_present)
                    begin
                        result_next = {ent_pfn, va_reg[ptw_pkg::OFS_W-1:0]};
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            lv_reg    <= '0;
            frame_reg <= '0;
            free_reg  <= NW'(1);
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lv_reg    <= lv_next;
            frame_reg <= frame_next;
            free_reg  <= free_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        if (accept)
        begin
            func_reg <= in_func;
            va_reg   <= in_va;
            leaf_reg <= {in_pa[ptw_pkg::PA_W-1:ptw_pkg::OFS_W], in_flags};
        end
    end

endmodule

FILE: rtl/core/ptw_checker.sv
// Port-level checks for the page table walker core, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_core.
module ptw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [ptw_pkg::FUNC_W-1:0]        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ptw_pkg::M_DATA_W-1:0]      m_tdata,
    input logic [ptw_pkg::STATUS_W-1:0]      m_tuser
);

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != ptw_pkg::ST_RESERVED)
        else $error("reserved status code on output");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ptw_pkg::ST_OK |-> m_tdata == '0)
        else $error("nonzero address with failing status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/ptw_walk_checker_pkg.sv
// Scoreboard for the page table walker: keeps its own copy of the table store
// and frame allocator, predicts each response and checks the returned words.
// Depends on ptw_pkg.
package ptw_walk_checker_pkg;

    import ptw_pkg::*;

    class page_walk_checker;

        logic [ENTRY_W-1:0] table_entries [int];
        int unsigned        next_frame;
        res_t               awaited [$];
        int                 errors;

        function new();
            next_frame = 1;
            errors     = 0;
        endfunction

        function int slot_key(input int unsigned frame, input logic [IDX_W-1:0] idx);
            return frame * SLOTS + idx;
        endfunction

        function logic [ENTRY_W-1:0] read_slot(input int key);
            return table_entries.exists(key) ? table_entries[key] : '0;
        endfunction

        // level 0 is the root, indexed by va[47:39]
        function logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va, input int lv);
            return va[39 - 9 * lv +: IDX_W];
        endfunction

        function bit next_table(input logic [ENTRY_W-1:0] e, output int unsigned frame);
            logic [PFN_W-1:0] pfn;
            pfn   = e[ENTRY_W-1:OFS_W];
            frame = 0;
            if (!e[0] || pfn >= TABLE_FRAMES_DEF)
                return 0;
            frame = int'(pfn);
            return 1;
        endfunction

        function bit find_leaf_table(input logic [VA_W-1:0] va, output int unsigned frame);
            int unsigned cur;
            int          lv;
            cur   = 0;
            frame = 0;
            for (lv = 0; lv < 3; lv++)
            begin
                if (!next_table(read_slot(slot_key(cur, level_idx(va, lv))), cur))
                    return 0;
            end
            frame = cur;
            return 1;
        endfunction

        function void note_request(input logic [FUNC_W-1:0] func,
                                   input logic [VA_W-1:0] va,
                                   input logic [PA_W-1:0] pa,
                                   input logic [OFS_W-1:0] flags);
            res_t               r;
            int unsigned        frame;
            int                 key;
            int                 lv;
            bit                 ok;
            logic [ENTRY_W-1:0] e;
            r     = '0;
            frame = 0;
            ok    = 1;
            case (func)
                FUNC_MAP:
                begin
                    for (lv = 0; lv < 3; lv++)
                    begin
                        key = slot_key(frame, level_idx(va, lv));
                        if (!next_table(read_slot(key), frame))
                        begin
                            // upper tables made so far stay in place
                            if (next_frame >= TABLE_FRAMES_DEF)
                            begin
                                ok = 0;
                                break;
                            end
                            table_entries[key] = (ENTRY_W'(next_frame) << OFS_W)
                                                 | ENTRY_W'(TABLE_FLAGS);
                            frame = next_frame;
                            next_frame++;
                        end
                    end
                    if (ok)
                        table_entries[slot_key(frame, level_idx(va, 3))] =
                            {pa[PA_W-1:OFS_W], flags};
                    else
                        r.status = ST_NO_FRAMES;
                end
                FUNC_UNMAP:
                begin
                    if (find_leaf_table(va, frame))
                    begin
                        key = slot_key(frame, level_idx(va, 3));
                        e   = read_slot(key);
                        if (!e[0])
                            r.status = ST_NOT_MAPPED;
                        table_entries[key] = '0;
                    end
                    else
                        r.status = ST_NOT_MAPPED;
                end
                FUNC_XLATE:
                begin
                    if (find_leaf_table(va, frame))
                    begin
                        e = read_slot(slot_key(frame, level_idx(va, 3)));
                        if (e[0])
                            r.result_addr = {e[ENTRY_W-1:OFS_W], va[OFS_W-1:0]};
                        else
                            r.status = ST_NOT_MAPPED;
                    end
                    else
                        r.status = ST_NOT_MAPPED;
                end
                default:
                begin
                end
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(input logic [STATUS_W-1:0] status,
                                   input logic [M_DATA_W-1:0] tdata);
            res_t                want;
            logic [M_DATA_W-1:0] want_data;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response word: status %0d addr %h",
                         $time, status, tdata);
                return;
            end
            want      = awaited.pop_front();
            want_data = M_DATA_W'(want.result_addr);
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
            end
            if (tdata !== want_data)
            begin
                errors++;
                $display("%0t: result_addr mismatch: expected %h actual %h",
                         $time, want_data, tdata);
            end
        endfunction

    endclass

endpackage

FILE: tb/four_level_page_table_walker_core_tb.sv
// Top-level testbench for four_level_page_table_walker_core: directed and
// random map, unmap and translate words under random stalls on both streams.
// Depends on ptw_pkg, ptw_walk_checker_pkg and the RTL under rtl/core.
module four_level_page_table_walker_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;
    import ptw_walk_checker_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT  = 200000;  // covers the store sweep after reset
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 560;
    localparam int RECENT_DEPTH = 48;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int  tx_idle_pct  = 14;
    int  rx_idle_pct  = 85;
    bit  hold_trigger = 1'b0;
    bit  hold_seen    = 1'b0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;

    logic [VA_W-1:0] recent_va [$];
    logic [26:0]     regions [6];  // va[47:21] of a few shared table paths

    page_walk_checker chk = new();

    four_level_page_table_walker_core #(
        .TABLE_FRAMES (TABLE_FRAMES_DEF)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            chk.note_request(s_tuser, s_tdata[47:0], s_tdata[99:48], s_tdata[111:100]);
        if (rst_n && m_tvalid && m_tready)
            chk.check_result(m_tuser, m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [VA_W-1:0] va,
                             input logic [PA_W-1:0] pa, input logic [OFS_W-1:0] flags);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {flags, pa, va};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random_word();
        logic [FUNC_W-1:0] fn;
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        logic [OFS_W-1:0]  flags;
        int                r;
        r = $urandom_range(99);
        if (r < 40)
            fn = FUNC_MAP;
        else if (r < 75)
            fn = FUNC_XLATE;
        else if (r < 95)
            fn = FUNC_UNMAP;
        else
            fn = FUNC_UNKNOWN;
        r = $urandom_range(99);
        if (r < 55 && recent_va.size() > 0)
        begin
            va = recent_va[$urandom_range(recent_va.size() - 1)];
            if ($urandom_range(3) == 0)
                va[OFS_W-1:0] = OFS_W'($urandom);
            if ($urandom_range(5) == 0)
                va[20:12] = 9'($urandom);
        end
        else if (r < 88)
            va = {regions[$urandom_range(5)], 21'($urandom)};
        else
            va = {16'($urandom), 32'($urandom)};
        pa    = {20'($urandom), 32'($urandom)};
        flags = OFS_W'($urandom);
        if ($urandom_range(9) != 0)
            flags[0] = 1'b1;
        if (fn == FUNC_MAP)
        begin
            recent_va.push_back(va);
            if (recent_va.size() > RECENT_DEPTH)
                void'(recent_va.pop_front());
        end
        send_word(fn, va, pa, flags);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        foreach (regions[k])
        begin
            regions[k] = 27'($urandom);
            if (k % 2 == 1)
                regions[k][26:18] = regions[k-1][26:18];
        end

        // empty table, then extremes, a leaf without present bit, unmap paths
        send_word(FUNC_XLATE, '0, '0, '0);
        send_word(FUNC_UNMAP, '0, '0, '0);
        send_word(FUNC_MAP, '0, '0, 12'h001);
        send_word(FUNC_XLATE, 48'h0000_0000_0FFF, '0, '0);
        send_word(FUNC_MAP, '1, '1, '1);
        send_word(FUNC_XLATE, '1, '0, '0);
        send_word(FUNC_XLATE, 48'hFFFF_FFFF_EFFF, '0, '0);
        send_word(FUNC_MAP, 48'h0000_0000_1000, '1, 12'hFFE);
        send_word(FUNC_XLATE, 48'h0000_0000_1ABC, '0, '0);
        send_word(FUNC_UNMAP, 48'h0000_0000_1000, '0, '0);
        send_word(FUNC_UNMAP, '0, '0, '0);
        send_word(FUNC_XLATE, '0, '0, '0);
        send_word(FUNC_UNMAP, '0, '0, '0);
        send_word(FUNC_UNMAP, 48'h0000_4000_0000, '0, '0);
        send_word(FUNC_UNKNOWN, '1, '1, '1);
        send_word(FUNC_MAP, 48'h8000_0000_0000, 52'hA_AAAA_AAAA_A555, 12'hA5B);
        send_word(FUNC_XLATE, 48'h8000_0000_0AAA, '0, '0);
        send_word(FUNC_MAP, 48'h5555_5555_5555, 52'h5_5555_5555_5AAA, 12'h555);
        send_word(FUNC_XLATE, 48'h5555_5555_5000, '0, '0);

        repeat (PHASE_ITEMS) send_random_word();

        tx_idle_pct = 85;
        rx_idle_pct <= 14;
        repeat (PHASE_ITEMS) send_random_word();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_trigger <= ~hold_trigger;
        repeat (PHASE_ITEMS) send_random_word();

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chk.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (chk.errors == 0 && chk.awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
